// ----- sv/ifmt_pkg.sv -----
// integer field formatter: shared constants, codes, layout struct and digit lookup
// used by every module of the block; no dependencies
`default_nettype none

package ifmt_pkg;

    localparam int MAX_WIDTH    = 32;
    localparam int RESULT_LIMIT = 32;
    localparam int FIELD_CAP    = (MAX_WIDTH < RESULT_LIMIT) ? MAX_WIDTH : RESULT_LIMIT;

    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 22;   // enough for 64 bits in octal
    localparam int DIG_IDX_W  = 5;
    localparam int DIG_CNT_W  = 5;
    localparam int POS_W      = 6;
    localparam int BIT_CNT_W  = 6;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [7:0] HEX_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };
    localparam logic [7:0] HEX_LOWER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [2:0] {
        CONV_SDEC   = 3'd0,
        CONV_UDEC   = 3'd1,
        CONV_HEX_LO = 3'd2,
        CONV_HEX_UP = 3'd3,
        CONV_OCT    = 3'd4,
        CONV_PTR    = 3'd5
    } conv_t;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_HEX,
        RADIX_OCT
    } radix_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LAYOUT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             prefix;
        logic             sign_en;
        logic [7:0]       sign_char;
        logic [7:0]       fill_char;
        logic             upper;
        logic [POS_W-1:0] sign_pos;
        logic [POS_W-1:0] dig_start;
        logic [POS_W-1:0] dig_end;
        logic [POS_W-1:0] total;
    } layout_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        return upper ? HEX_UPPER[d] : HEX_LOWER[d];
    endfunction

endpackage

`default_nettype wire

// ----- sv/integer_field_formatter_core.sv -----
// integer field formatter top level: request capture, magnitude, field layout and
// control sequencer; instantiates ifmt_conv and ifmt_emit, depends on ifmt_pkg
//
// usage
//   s_ channel: one request per formatted integer (conversion, 64-bit value, field
//   width, zero-pad, left-align and plus flags), valid/ready handshake.
//   m_ channel: the ascii characters of the field, first character first, one per
//   handshake, m_last high on the final one.
//   a request is captured, converted bit-serially (one operand bit per cycle through
//   the digit cells), flagged done by the converter and laid out in the layout
//   state; the character sequencer then starts and loads the characters one at a
//   time into the output register.
//   s_ready is high only between requests; a request with an unused conversion
//   code is taken and dropped, and s_ready stays high.
//   the next request is taken as soon as the last character sits in the output
//   register, so its conversion overlaps the receiver taking that character.
//   while m_ready is low the current character holds and the sequencer waits.
//   reset (aresetn low, synchronous) drops any request in progress and clears
//   m_valid; the data registers are not reset.
`default_nettype none

module integer_field_formatter_core
    import ifmt_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [2:0]   s_conversion,
    input  wire logic [63:0]  s_value,
    input  wire logic [5:0]   s_field_width,
    input  wire logic         s_zero_pad,
    input  wire logic         s_left_align,
    input  wire logic         s_plus_sign,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [7:0]        m_character,
    output logic              m_last
);

    state_t               state_reg, state_next;
    logic [2:0]           conv_reg;
    logic [POS_W-1:0]     width_reg;
    logic                 zpad_reg;
    logic                 left_reg;
    logic                 plus_reg;
    logic                 neg_reg;

    logic                 accept;
    logic                 code_ok;
    logic                 start_conv;
    logic [VALUE_W-1:0]   mag_in;
    radix_t               radix_in;
    logic                 conv_done;
    logic [DIG_CNT_W-1:0] ndig;
    logic [DIG_IDX_W-1:0] rd_idx;
    logic [3:0]           rd_digit;
    logic                 emit_start;
    logic                 emit_done;
    layout_t              layout;
    logic [POS_W-1:0]     ndig_w;
    logic [POS_W-1:0]     numlen;
    logic [POS_W-1:0]     total;
    logic [POS_W-1:0]     pad;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign code_ok    = (s_conversion <= CONV_PTR);
    assign start_conv = accept && code_ok;

    assign mag_in = (s_conversion == CONV_SDEC && s_value[VALUE_W-1])
                  ? (~s_value + VALUE_W'(1)) : s_value;

    always_comb begin
        unique case (s_conversion) inside
            CONV_HEX_LO, CONV_HEX_UP, CONV_PTR: radix_in = RADIX_HEX;
            CONV_OCT:                           radix_in = RADIX_OCT;
            default:                            radix_in = RADIX_DEC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (start_conv) begin
            conv_reg  <= s_conversion;
            width_reg <= (s_field_width > POS_W'(FIELD_CAP)) ? POS_W'(FIELD_CAP)
                                                              : s_field_width;
            zpad_reg  <= s_zero_pad;
            left_reg  <= s_left_align;
            plus_reg  <= s_plus_sign;
            neg_reg   <= (s_conversion == CONV_SDEC) && s_value[VALUE_W-1];
        end
    end

    // field layout: sign position, digit window and fill character
    always_comb begin
        layout.prefix    = (conv_reg == CONV_PTR);
        layout.sign_en   = (conv_reg == CONV_SDEC) && (neg_reg || plus_reg);
        layout.sign_char = neg_reg ? CH_MINUS : CH_PLUS;
        layout.upper     = (conv_reg == CONV_HEX_UP);
        ndig_w           = POS_W'(ndig);
        numlen           = ndig_w + POS_W'(layout.sign_en);
        if (conv_reg == CONV_PTR) begin
            total = ndig_w + POS_W'(2);
        end else begin
            total = (width_reg > numlen) ? width_reg : numlen;
        end
        pad              = total - numlen;
        layout.total     = total;
        layout.fill_char = CH_SPACE;
        layout.sign_pos  = '0;
        layout.dig_start = total - ndig_w;
        layout.dig_end   = total;
        if (conv_reg == CONV_PTR) begin
            layout.dig_start = POS_W'(2);
        end else if (left_reg) begin
            layout.dig_start = POS_W'(layout.sign_en);
            layout.dig_end   = numlen;
        end else if (zpad_reg) begin
            layout.fill_char = CH_ZERO;
        end else begin
            layout.sign_pos  = pad;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        emit_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_conv) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    state_next = ST_LAYOUT;
                end
            end
            ST_LAYOUT: begin
                emit_start = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    ifmt_conv u_conv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_conv),
        .mag      (mag_in),
        .radix    (radix_in),
        .done     (conv_done),
        .ndig     (ndig),
        .rd_idx   (rd_idx),
        .rd_digit (rd_digit)
    );

    ifmt_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (emit_start),
        .layout      (layout),
        .rd_idx      (rd_idx),
        .rd_digit    (rd_digit),
        .done        (emit_done),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

`default_nettype wire

// ----- sv/ifmt_conv.sv -----
// integer field formatter: bit-serial radix converter, one operand bit per cycle
// into a chain of digit cells (double dabble for decimal); depends on ifmt_pkg
`default_nettype none

module ifmt_conv
    import ifmt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [VALUE_W-1:0]   mag,
    input  wire radix_t               radix,
    output logic                      done,
    output logic [DIG_CNT_W-1:0]      ndig,
    input  wire logic [DIG_IDX_W-1:0] rd_idx,
    output logic [3:0]                rd_digit
);

    logic [VALUE_W-1:0]   shift_reg;
    logic [3:0]           digit_reg  [NUM_DIGITS];
    logic [3:0]           digit_next [NUM_DIGITS];
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [DIG_CNT_W-1:0] ndig_reg;
    radix_t               radix_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 carry;
    logic [3:0]           adj;
    logic                 grow;

    // every cell's carry out comes from its old value only, so the chain is flat
    always_comb begin
        carry = shift_reg[VALUE_W-1];
        adj   = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            unique case (radix_reg)
                RADIX_DEC: begin
                    adj           = (digit_reg[i] >= 4'd5) ? digit_reg[i] + 4'd3 : digit_reg[i];
                    digit_next[i] = {adj[2:0], carry};
                    carry         = adj[3];
                end
                RADIX_OCT: begin
                    digit_next[i] = {1'b0, digit_reg[i][1:0], carry};
                    carry         = digit_reg[i][2];
                end
                default: begin
                    digit_next[i] = {digit_reg[i][2:0], carry};
                    carry         = digit_reg[i][3];
                end
            endcase
        end
    end

    // significant digits grow by at most one per shifted bit
    assign grow = (ndig_reg < DIG_CNT_W'(NUM_DIGITS))
               && (digit_next[ndig_reg[DIG_IDX_W-1:0]] != 4'd0);

    assign ndig     = (ndig_reg == '0) ? DIG_CNT_W'(1) : ndig_reg;
    assign rd_digit = (rd_idx < DIG_IDX_W'(NUM_DIGITS)) ? digit_reg[rd_idx] : 4'd0;
    assign done     = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_cnt_reg == '1) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg   <= mag;
            radix_reg   <= radix;
            bit_cnt_reg <= '0;
            ndig_reg    <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                digit_reg[i] <= 4'd0;
            end
        end else if (busy_reg) begin
            shift_reg   <= {shift_reg[VALUE_W-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
            ndig_reg    <= ndig_reg + DIG_CNT_W'(grow);
            for (int i = 0; i < NUM_DIGITS; i++) begin
                digit_reg[i] <= digit_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/ifmt_emit.sv -----
// integer field formatter: character sequencer and output register, one character
// per cycle unless stalled, from layout and digit cells; depends on ifmt_pkg
`default_nettype none

module ifmt_emit
    import ifmt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire layout_t              layout,
    output logic [DIG_IDX_W-1:0]      rd_idx,
    input  wire logic [3:0]           rd_digit,
    output logic                      done,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_character,
    output logic                      m_last
);

    layout_t          lay_reg;
    logic [POS_W-1:0] pos_reg;
    logic             busy_reg;
    logic             m_valid_reg;
    logic [7:0]       m_char_reg;
    logic             m_last_reg;
    logic [POS_W-1:0] dig_off;
    logic [7:0]       ch;
    logic             is_last;
    logic             load;

    // digits leave most significant first, so the cell index counts down
    assign dig_off = lay_reg.dig_end - POS_W'(1) - pos_reg;
    assign rd_idx  = dig_off[DIG_IDX_W-1:0];

    always_comb begin
        if (lay_reg.prefix && pos_reg == POS_W'(0)) begin
            ch = CH_ZERO;
        end else if (lay_reg.prefix && pos_reg == POS_W'(1)) begin
            ch = CH_X;
        end else if (lay_reg.sign_en && pos_reg == lay_reg.sign_pos) begin
            ch = lay_reg.sign_char;
        end else if (pos_reg >= lay_reg.dig_start && pos_reg < lay_reg.dig_end) begin
            ch = digit_char(rd_digit, lay_reg.upper);
        end else begin
            ch = lay_reg.fill_char;
        end
    end

    assign is_last = (pos_reg == lay_reg.total - POS_W'(1));
    assign load    = busy_reg && (!m_valid_reg || m_ready);
    assign done    = load && is_last;

    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last      = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                pos_reg  <= '0;
            end else if (load) begin
                pos_reg <= pos_reg + POS_W'(1);
                if (is_last) begin
                    busy_reg <= 1'b0;
                end
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            lay_reg <= layout;
        end
        if (load) begin
            m_char_reg <= ch;
            m_last_reg <= is_last;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ifmt_checker.sv -----
// integer field formatter: port-level checker and its bind to the top level
// depends on ifmt_pkg for the conversion codes
`default_nettype none

module ifmt_checker
    import ifmt_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [2:0]  s_conversion,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_character,
    input wire logic        m_last
);

    // a stalled character holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_character) && $stable(m_last))
        else $error("stalled output character changed");

    // a formatted request takes the input out of ready once it is taken
    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_conversion <= CONV_PTR) |=> !s_ready)
        else $error("input still ready after a formatted request");

    // an unused conversion code is dropped without leaving idle
    a_drop_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_conversion > CONV_PTR) |=> s_ready)
        else $error("unused conversion code left the block busy");

    // only printable characters come out
    a_printable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_character >= CH_SPACE) && (m_character < 8'h7F))
        else $error("non-printable character on output");

endmodule

bind integer_field_formatter_core ifmt_checker u_ifmt_checker (.*);

`default_nettype wire
